/* rtl/core/iirdf2_pkg.sv */
package iirdf2_pkg;

   localparam int MAX_ORDER      = 8;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 28;
   localparam int COEF_BITS      = 32;
   localparam int STATE_BITS     = 40;
   localparam int STATE_FRAC     = 16;

   localparam int ORDER_BITS    = 4;
   localparam int OP_BITS       = 3;
   localparam int LOAD_IDX_BITS = 4;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 4;

   // index widths of the tap stores
   localparam int DIDX_W   = $clog2(MAX_ORDER + 1);
   localparam int IC_IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   // a state word is multiplied in two halves: low fraction part, then high part
   localparam int DLO_BITS = STATE_FRAC;
   localparam int DHI_BITS = STATE_BITS - STATE_FRAC;
   localparam int MOP_BITS = (DLO_BITS + 1 > DHI_BITS) ? DLO_BITS + 1 : DHI_BITS;
   localparam int PROD_BITS = COEF_BITS + MOP_BITS;

   localparam int FULL_PROD_BITS = COEF_BITS + STATE_BITS;
   localparam int X_TERM_BITS    = SAMPLE_BITS + COEF_FRAC_BITS + STATE_FRAC;
   localparam int ACC_BITS = ((FULL_PROD_BITS > X_TERM_BITS) ? FULL_PROD_BITS : X_TERM_BITS)
                             + $clog2(MAX_ORDER + 2);

   localparam int W_SHIFT = COEF_FRAC_BITS;
   localparam int Y_SHIFT = COEF_FRAC_BITS + STATE_FRAC;

   // request opcodes
   localparam logic [OP_BITS-1:0] OP_SAMPLE  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_NUM     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_DEN     = 3'd2;
   localparam logic [OP_BITS-1:0] OP_IC      = 3'd3;
   localparam logic [OP_BITS-1:0] OP_RESTART = 3'd4;

   // csr indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_ORDER = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REAL_TIME    = 4'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESTART,
      ST_TAP_LO,
      ST_TAP_HI,
      ST_DRAIN,
      ST_W_RND,
      ST_B0_LO,
      ST_B0_HI,
      ST_Y_DRAIN,
      ST_Y_RND
   } state_type;

   typedef struct packed {
      logic init;     // load the w accumulator with the input term, clear the y one
      logic mul_en;   // multiply this cycle
      logic mul_hi;   // high half of the state word
      logic mul_w;    // feed the feedback accumulator too
   } mac_ctl_type;

endpackage

/* rtl/core/iirdf2_mac.sv */
module iirdf2_mac
   import iirdf2_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] x,
   input  logic signed [COEF_BITS-1:0]   coef_a,
   input  logic signed [COEF_BITS-1:0]   coef_b,
   input  logic signed [STATE_BITS-1:0]  data,
   output logic signed [STATE_BITS-1:0]  w_value,
   output logic                          w_clip,
   output logic signed [SAMPLE_BITS-1:0] y_value,
   output logic                          y_clip
);

   localparam logic signed [ACC_BITS-1:0] W_MAX =
      (ACC_BITS'(1) <<< (STATE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] W_MIN = -W_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] Y_MAX =
      (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] W_HALF = ACC_BITS'(1) <<< (W_SHIFT - 1);
   localparam logic signed [ACC_BITS-1:0] Y_HALF = ACC_BITS'(1) <<< (Y_SHIFT - 1);

   logic signed [MOP_BITS-1:0]  mop;
   logic signed [PROD_BITS-1:0] pa_in, pb_in;
   logic signed [PROD_BITS-1:0] pa_ff, pb_ff;
   logic                        pv_ff, phi_ff, pw_ff;
   logic signed [ACC_BITS-1:0]  ta, tb;
   logic signed [ACC_BITS-1:0]  accw_ff, accw_in, accy_ff, accy_in;
   logic signed [ACC_BITS-1:0]  w_sum, w_q, y_sum, y_q;

   // low half is an unsigned fraction, high half carries the sign
   always_comb begin
      if (ctl.mul_hi) begin
         mop = MOP_BITS'(signed'(data[STATE_BITS-1:STATE_FRAC]));
      end else begin
         mop = MOP_BITS'({1'b0, data[STATE_FRAC-1:0]});
      end
   end

   assign pa_in = coef_a * mop;
   assign pb_in = coef_b * mop;

   always_ff @(posedge clock) begin
      pa_ff <= pa_in;
      pb_ff <= pb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= 1'b0;
         phi_ff <= 1'b0;
         pw_ff  <= 1'b0;
      end else begin
         pv_ff  <= ctl.mul_en;
         phi_ff <= ctl.mul_hi;
         pw_ff  <= ctl.mul_w;
      end
   end

   assign ta = phi_ff ? (ACC_BITS'(pa_ff) <<< STATE_FRAC) : ACC_BITS'(pa_ff);
   assign tb = phi_ff ? (ACC_BITS'(pb_ff) <<< STATE_FRAC) : ACC_BITS'(pb_ff);

   always_comb begin
      accw_in = accw_ff;
      accy_in = accy_ff;
      if (ctl.init) begin
         accw_in = ACC_BITS'(x) <<< (COEF_FRAC_BITS + STATE_FRAC);
         accy_in = '0;
      end else if (pv_ff) begin
         accy_in = accy_ff + tb;
         if (pw_ff) begin
            accw_in = accw_ff - ta;
         end
      end
   end

   always_ff @(posedge clock) begin
      accw_ff <= accw_in;
      accy_ff <= accy_in;
   end

   // round half up, then clip
   assign w_sum = accw_ff + W_HALF;
   assign w_q   = w_sum >>> W_SHIFT;
   assign y_sum = accy_ff + Y_HALF;
   assign y_q   = y_sum >>> Y_SHIFT;

   always_comb begin
      w_clip = 1'b0;
      if (w_q > W_MAX) begin
         w_value = STATE_BITS'(W_MAX);
         w_clip  = 1'b1;
      end else if (w_q < W_MIN) begin
         w_value = STATE_BITS'(W_MIN);
         w_clip  = 1'b1;
      end else begin
         w_value = STATE_BITS'(w_q);
      end
   end

   always_comb begin
      y_clip = 1'b0;
      if (y_q > Y_MAX) begin
         y_value = SAMPLE_BITS'(Y_MAX);
         y_clip  = 1'b1;
      end else if (y_q < Y_MIN) begin
         y_value = SAMPLE_BITS'(Y_MIN);
         y_clip  = 1'b1;
      end else begin
         y_value = SAMPLE_BITS'(y_q);
      end
   end

endmodule

/* rtl/core/iir_direct_form2_filter_core.sv */
// Direct form II IIR filter core, one shared pair of multipliers.
// req_ channel: one beat is a sample, a coefficient load, an initial
// condition load or a restart, selected by req_op. Only a sample beat
// produces an rsp_ beat (filtered value, last_out, saturated flag).
// csr_ channel: filter_order (index 0) and real_time_mode (index 1);
// always ready, write only while no sample is in flight.
// Sequencing: a load beat is written while the core stays idle. A
// restart copies one delay entry per cycle from the initial condition
// store. A sample walks the taps through the delay memory, a low and a
// high step per tap for the split 32x40 products; rsp_valid rises as
// the core returns to idle, where the next beat can already be taken.
// The result sits in an output register: a new beat is accepted while
// the receiver stalls, and only the final output step waits for the
// register to empty. Reset clears configuration, coefficients, initial
// conditions and the delay line through per-entry valid bits.
module iir_direct_form2_filter_core
   import iirdf2_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [OP_BITS-1:0]              req_op,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,
   input  logic                            req_last_in_block,
   input  logic [LOAD_IDX_BITS-1:0]        req_load_index,
   input  logic signed [STATE_BITS-1:0]    req_load_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]   rsp_filtered,
   output logic                            rsp_last_out,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_IDX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]        csr_wdata
);

   localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

   state_type state_ff, state_in;
   logic [ORDER_BITS-1:0] filter_order_ff;
   logic                  rt_ff;
   logic [DIDX_W-1:0]     order_sel;
   logic [DIDX_W-1:0]     tap_ff, tap_in;
   logic [DIDX_W-1:0]     rs_cnt_ff, rs_cnt_in;
   logic                  rs_wr_ff, rs_wr_in;
   logic                  last_ff;
   logic signed [STATE_BITS-1:0] w_ff;
   logic                  clip_ff;
   logic                  rsp_valid_ff, rsp_last_ff, rsp_sat_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_filt_ff;

   // tap stores
   logic [COEF_BITS-1:0]  num_mem [MAX_ORDER+1];
   logic [COEF_BITS-1:0]  den_mem [MAX_ORDER+1];
   logic [STATE_BITS-1:0] dly_mem [MAX_ORDER+1];
   logic [STATE_BITS-1:0] ic_mem  [MAX_ORDER];
   logic [MAX_ORDER:0]    num_vld_ff, den_vld_ff, dly_vld_ff;
   logic [MAX_ORDER-1:0]  ic_vld_ff;

   logic [COEF_BITS-1:0]  num_rd_ff, den_rd_ff;
   logic                  num_ok_ff, den_ok_ff;
   logic [STATE_BITS-1:0] dly_rd_ff, ic_rd_ff;
   logic                  dly_ok_ff, ic_ok_ff;
   logic signed [COEF_BITS-1:0]  num_q, den_q;
   logic signed [STATE_BITS-1:0] dly_q, ic_q;

   logic                  req_acc;
   logic                  num_we, den_we, ic_we;
   logic [DIDX_W-1:0]     coef_waddr;
   logic [IC_IDX_W-1:0]   ic_waddr;
   logic signed [COEF_BITS-1:0] coef_sat;
   logic                  coef_re;
   logic [DIDX_W-1:0]     coef_raddr;
   logic                  d_re, d_we;
   logic [DIDX_W-1:0]     d_raddr, d_waddr;
   logic [STATE_BITS-1:0] d_wdata;
   logic                  dly_clr;
   logic                  ic_re;
   logic [IC_IDX_W-1:0]   ic_raddr;
   logic                  w_load, out_load, sample_go;

   mac_ctl_type                  mac_ctl;
   logic signed [STATE_BITS-1:0] mac_data;
   logic signed [STATE_BITS-1:0] w_value;
   logic                         w_clip;
   logic signed [SAMPLE_BITS-1:0] y_value;
   logic                         y_clip;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign order_sel = (32'(filter_order_ff) > 32'(MAX_ORDER)) ?
                      DIDX_W'(MAX_ORDER) : DIDX_W'(filter_order_ff);

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff <= '0;
         rt_ff           <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILTER_ORDER: filter_order_ff <= csr_wdata[ORDER_BITS-1:0];
            CSR_REAL_TIME:    rt_ff           <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // coefficient clip to 32 bits
   always_comb begin
      if ((&req_load_value[STATE_BITS-1:COEF_BITS-1]) ||
          !(|req_load_value[STATE_BITS-1:COEF_BITS-1])) begin
         coef_sat = req_load_value[COEF_BITS-1:0];
      end else if (req_load_value[STATE_BITS-1]) begin
         coef_sat = COEF_MIN;
      end else begin
         coef_sat = COEF_MAX;
      end
   end

   assign coef_waddr = DIDX_W'(req_load_index);
   assign ic_waddr   = IC_IDX_W'(req_load_index);

   assign num_q = num_ok_ff ? signed'(num_rd_ff) : '0;
   assign den_q = den_ok_ff ? signed'(den_rd_ff) : '0;
   assign dly_q = dly_ok_ff ? signed'(dly_rd_ff) : '0;
   assign ic_q  = ic_ok_ff  ? signed'(ic_rd_ff)  : '0;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      rs_cnt_in  = rs_cnt_ff;
      rs_wr_in   = rs_wr_ff;
      num_we     = 1'b0;
      den_we     = 1'b0;
      ic_we      = 1'b0;
      coef_re    = 1'b0;
      coef_raddr = '0;
      d_re       = 1'b0;
      d_raddr    = '0;
      d_we       = 1'b0;
      d_waddr    = '0;
      d_wdata    = dly_q;
      dly_clr    = 1'b0;
      ic_re      = 1'b0;
      ic_raddr   = '0;
      w_load     = 1'b0;
      out_load   = 1'b0;
      sample_go  = 1'b0;
      mac_ctl    = '0;
      mac_data   = dly_q;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_SAMPLE: begin
                     sample_go   = 1'b1;
                     mac_ctl.init = 1'b1;
                     if (order_sel != '0) begin
                        d_re       = 1'b1;
                        d_raddr    = order_sel - DIDX_W'(1);
                        coef_re    = 1'b1;
                        coef_raddr = order_sel;
                        tap_in     = order_sel;
                        state_in   = ST_TAP_LO;
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
                  OP_NUM: num_we = (32'(req_load_index) <= 32'(MAX_ORDER));
                  OP_DEN: den_we = (32'(req_load_index) <= 32'(MAX_ORDER));
                  OP_IC:  ic_we  = (32'(req_load_index) < 32'(MAX_ORDER));
                  OP_RESTART: begin
                     dly_clr   = 1'b1;
                     rs_cnt_in = '0;
                     rs_wr_in  = 1'b0;
                     state_in  = ST_RESTART;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESTART: begin
            // read ic[n] while writing the registered ic[n-1] word into d[n-1]
            if (rs_cnt_ff < order_sel) begin
               ic_re    = 1'b1;
               ic_raddr = IC_IDX_W'(rs_cnt_ff);
            end
            if (rs_wr_ff) begin
               d_we    = 1'b1;
               d_waddr = rs_cnt_ff - DIDX_W'(1);
               d_wdata = ic_q;
            end
            rs_wr_in = (rs_cnt_ff < order_sel);
            if (rs_cnt_ff == order_sel) begin
               state_in = ST_IDLE;
            end else begin
               rs_cnt_in = rs_cnt_ff + DIDX_W'(1);
            end
         end
         ST_TAP_LO: begin
            // shift: old d[tap-1] moves into d[tap] and feeds tap's products
            d_we           = 1'b1;
            d_waddr        = tap_ff;
            d_wdata        = dly_q;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.mul_w  = 1'b1;
            state_in       = ST_TAP_HI;
         end
         ST_TAP_HI: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.mul_hi = 1'b1;
            mac_ctl.mul_w  = 1'b1;
            if (tap_ff > DIDX_W'(1)) begin
               tap_in     = tap_ff - DIDX_W'(1);
               d_re       = 1'b1;
               d_raddr    = tap_ff - DIDX_W'(2);
               coef_re    = 1'b1;
               coef_raddr = tap_ff - DIDX_W'(1);
               state_in   = ST_TAP_LO;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            coef_re    = 1'b1;
            coef_raddr = '0;
            state_in   = ST_W_RND;
         end
         ST_W_RND: begin
            w_load   = 1'b1;
            d_we     = 1'b1;
            d_waddr  = '0;
            d_wdata  = w_value;
            state_in = ST_B0_LO;
         end
         ST_B0_LO: begin
            mac_data       = w_ff;
            mac_ctl.mul_en = 1'b1;
            state_in       = ST_B0_HI;
         end
         ST_B0_HI: begin
            mac_data       = w_ff;
            mac_ctl.mul_en = 1'b1;
            mac_ctl.mul_hi = 1'b1;
            state_in       = ST_Y_DRAIN;
         end
         ST_Y_DRAIN: begin
            state_in = ST_Y_RND;
         end
         ST_Y_RND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               dly_clr  = last_ff && !rt_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tap_ff    <= '0;
         rs_cnt_ff <= '0;
         rs_wr_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tap_ff    <= tap_in;
         rs_cnt_ff <= rs_cnt_in;
         rs_wr_ff  <= rs_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_go) begin
         last_ff <= req_last_in_block;
      end
      if (w_load) begin
         w_ff    <= w_value;
         clip_ff <= w_clip;
      end
   end

   // coefficient memories
   always_ff @(posedge clock) begin
      if (num_we) begin
         num_mem[coef_waddr] <= coef_sat;
      end
      if (den_we) begin
         den_mem[coef_waddr] <= coef_sat;
      end
      if (coef_re) begin
         num_rd_ff <= num_mem[coef_raddr];
         den_rd_ff <= den_mem[coef_raddr];
         num_ok_ff <= num_vld_ff[coef_raddr];
         den_ok_ff <= den_vld_ff[coef_raddr];
      end
   end

   // delay line memory
   always_ff @(posedge clock) begin
      if (d_we) begin
         dly_mem[d_waddr] <= d_wdata;
      end
      if (d_re) begin
         dly_rd_ff <= dly_mem[d_raddr];
         dly_ok_ff <= dly_vld_ff[d_raddr];
      end
   end

   // initial condition memory
   always_ff @(posedge clock) begin
      if (ic_we) begin
         ic_mem[ic_waddr] <= req_load_value;
      end
      if (ic_re) begin
         ic_rd_ff <= ic_mem[ic_raddr];
         ic_ok_ff <= ic_vld_ff[ic_raddr];
      end
   end

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff <= '0;
         den_vld_ff <= '0;
         ic_vld_ff  <= '0;
      end else begin
         if (num_we) begin
            num_vld_ff[coef_waddr] <= 1'b1;
         end
         if (den_we) begin
            den_vld_ff[coef_waddr] <= 1'b1;
         end
         if (ic_we) begin
            ic_vld_ff[ic_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dly_clr) begin
         dly_vld_ff <= '0;
      end else if (d_we) begin
         dly_vld_ff[d_waddr] <= 1'b1;
      end
   end

   iirdf2_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .x       (req_sample),
      .coef_a  (den_q),
      .coef_b  (num_q),
      .data    (mac_data),
      .w_value (w_value),
      .w_clip  (w_clip),
      .y_value (y_value),
      .y_clip  (y_clip)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_filt_ff <= y_value;
         rsp_last_ff <= last_ff;
         rsp_sat_ff  <= clip_ff || y_clip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filt_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Y_RND && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished sample did not post a result");

   a_dly_waddr_range: assert property (@(posedge clock) disable iff (reset)
      d_we |-> (32'(d_waddr) <= 32'(MAX_ORDER)))
      else $error("delay write beyond the delay line");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAP_LO || state_ff == ST_TAP_HI) |->
         (tap_ff != '0 && tap_ff <= order_sel))
      else $error("tap counter out of range");

   a_dly_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (d_re && d_we) |-> (d_raddr != d_waddr))
      else $error("delay read and write hit the same entry");

   a_block_end_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Y_RND && state_in == ST_IDLE && last_ff && !rt_ff) |=>
         (dly_vld_ff == '0))
      else $error("delay line not cleared after block end");

endmodule
